@@ src/oproj_pkg.sv @@
// Package: item types, register indexes and pipeline records for the plane projector.
`default_nettype none
package oproj_pkg;

	localparam int DIV_STEPS = 42;
	localparam int CHUNK_W = 22;
	localparam int PROD_W = 98;
	localparam logic [40:0] QCAP = 41'h100_0000_0000;

	localparam logic [3:0] REG_NORMAL_X = 4'd0;
	localparam logic [3:0] REG_NORMAL_Y = 4'd1;
	localparam logic [3:0] REG_NORMAL_Z = 4'd2;
	localparam logic [3:0] REG_DIR_X = 4'd3;
	localparam logic [3:0] REG_DIR_Y = 4'd4;
	localparam logic [3:0] REG_DIR_Z = 4'd5;
	localparam logic [3:0] REG_PLANE_OFFSET = 4'd6;
	localparam logic [3:0] REG_ORTHO_TOL = 4'd7;

	typedef struct packed {
		logic opcode;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic parallel;
		logic saturated;
	} out_item_t;

	typedef struct packed {
		logic par;
		logic [2:0] neg;
		logic [2:0][31:0] x;
		logic [63:0] den;
	} carry_t;

	typedef struct packed {
		logic [63:0] r;
		logic [41:0] low;
		logic [41:0] q;
		logic ovf;
	} div_t;

endpackage
`default_nettype wire

@@ src/oblique_plane_projection.sv @@
// Top level: pipelined oblique projection of points and vectors onto a plane.
`default_nettype none
// Each transaction is projected along the configured direction onto the configured plane.
// The pipeline takes one transaction per cycle while the output is not stalled: six stages
// form the dot products, the magnitudes and the partial products and check the quotient for
// overflow, 42 stages run a restoring divider at one quotient bit per stage, and one stage
// applies the sign and saturates. A stall at the output holds the whole pipeline. Write
// configuration only while no transaction is in flight.
module oblique_plane_projection (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire oproj_pkg::in_item_t  in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output oproj_pkg::out_item_t      out_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [3:0]           cfg_index,
	input  wire logic [63:0]          cfg_data
);
	import oproj_pkg::*;

	logic signed [31:0] nrm_q [3];
	logic signed [31:0] dir_q [3];
	logic [63:0] off_q;
	logic [62:0] tol_q;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic dv_v_s [DIV_STEPS+1];

	logic opc_s1;
	logic [2:0][31:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic signed [63:0] pn_s1 [3];
	logic signed [63:0] px_s1 [3];
	logic signed [66:0] den_s2, num_s2;
	logic [63:0] den_s3, den_s4, den_s5;
	logic [65:0] num_s3;
	logic den_neg_s3, num_neg_s3, par_s3, par_s4, par_s5;
	logic [2:0] neg_s4, neg_s5;
	logic [53:0] pp_s4 [3][3];
	logic [PROD_W-1:0] prod_s5 [3];

	carry_t cr_s [DIV_STEPS+1];
	div_t dv_s [DIV_STEPS+1][3];

	assign cfg_ready = 1'b1;
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_q[0] <= '0;
			nrm_q[1] <= '0;
			nrm_q[2] <= 32'sd65536;
			dir_q[0] <= '0;
			dir_q[1] <= '0;
			dir_q[2] <= 32'sd65536;
			off_q <= '0;
			tol_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NORMAL_X: nrm_q[0] <= cfg_data[31:0];
				REG_NORMAL_Y: nrm_q[1] <= cfg_data[31:0];
				REG_NORMAL_Z: nrm_q[2] <= cfg_data[31:0];
				REG_DIR_X: dir_q[0] <= cfg_data[31:0];
				REG_DIR_Y: dir_q[1] <= cfg_data[31:0];
				REG_DIR_Z: dir_q[2] <= cfg_data[31:0];
				REG_PLANE_OFFSET: off_q <= cfg_data;
				REG_ORTHO_TOL: tol_q <= cfg_data[62:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) dv_v_s[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			dv_v_s[0] <= v_s5;
			for (int k = 1; k <= DIV_STEPS; k++) dv_v_s[k] <= dv_v_s[k-1];
			out_valid <= dv_v_s[DIV_STEPS];
		end
	end

	// dot products, magnitudes, parallel test and partial products
	always_ff @(posedge clk) begin
		if (adv) begin
			opc_s1 <= in_item.opcode;
			x_s1 <= {in_item.in_z, in_item.in_y, in_item.in_x};
			pn_s1[0] <= nrm_q[0] * dir_q[0];
			pn_s1[1] <= nrm_q[1] * dir_q[1];
			pn_s1[2] <= nrm_q[2] * dir_q[2];
			px_s1[0] <= nrm_q[0] * in_item.in_x;
			px_s1[1] <= nrm_q[1] * in_item.in_y;
			px_s1[2] <= nrm_q[2] * in_item.in_z;

			x_s2 <= x_s1;
			den_s2 <= 67'(pn_s1[0]) + 67'(pn_s1[1]) + 67'(pn_s1[2]);
			num_s2 <= 67'(px_s1[0]) + 67'(px_s1[1]) + 67'(px_s1[2])
				- (opc_s1 ? 67'($signed(off_q)) : 67'sd0);

			x_s3 <= x_s2;
			den_neg_s3 <= den_s2[66];
			num_neg_s3 <= num_s2[66];
			den_s3 <= den_s2[66] ? 64'(-den_s2) : den_s2[63:0];
			num_s3 <= num_s2[66] ? 66'(-num_s2) : num_s2[65:0];
			par_s3 <= (den_s2[66] ? 64'(-den_s2) : den_s2[63:0]) <= {1'b0, tol_q};

			x_s4 <= x_s3;
			den_s4 <= den_s3;
			par_s4 <= par_s3;
			for (int i = 0; i < 3; i++) begin
				neg_s4[i] <= num_neg_s3 ^ den_neg_s3 ^ dir_q[i][31];
				for (int c = 0; c < 3; c++) begin
					pp_s4[i][c] <= num_s3[c*CHUNK_W +: CHUNK_W]
						* (dir_q[i][31] ? 32'(-dir_q[i]) : 32'(dir_q[i]));
				end
			end

			x_s5 <= x_s4;
			den_s5 <= den_s4;
			par_s5 <= par_s4;
			neg_s5 <= neg_s4;
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= PROD_W'(pp_s4[i][0])
					+ (PROD_W'(pp_s4[i][1]) << CHUNK_W)
					+ (PROD_W'(pp_s4[i][2]) << (2 * CHUNK_W));
			end
		end
	end

	// quotient overflow check, divider entry
	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s[0].par <= par_s5;
			cr_s[0].neg <= neg_s5;
			cr_s[0].x <= x_s5;
			cr_s[0].den <= den_s5;
			for (int i = 0; i < 3; i++) begin
				dv_s[0][i].ovf <= {8'd0, prod_s5[i][PROD_W-1:DIV_STEPS]} >= den_s5;
				dv_s[0][i].r <= {8'd0, prod_s5[i][PROD_W-1:DIV_STEPS]};
				dv_s[0][i].low <= prod_s5[i][DIV_STEPS-1:0];
				dv_s[0][i].q <= '0;
			end
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		logic [64:0] t [3];
		logic [64:0] d [3];
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				t[i] = {dv_s[k-1][i].r, dv_s[k-1][i].low[DIV_STEPS-1]};
				d[i] = t[i] - {1'b0, cr_s[k-1].den};
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				cr_s[k] <= cr_s[k-1];
				for (int i = 0; i < 3; i++) begin
					dv_s[k][i].ovf <= dv_s[k-1][i].ovf;
					dv_s[k][i].low <= {dv_s[k-1][i].low[DIV_STEPS-2:0], 1'b0};
					dv_s[k][i].r <= d[i][64] ? t[i][63:0] : d[i][63:0];
					dv_s[k][i].q <= {dv_s[k-1][i].q[DIV_STEPS-2:0], !d[i][64]};
				end
			end
		end
	end

	// cap quotient, sign, subtract, saturate
	logic [40:0] qm [3];
	logic signed [42:0] qs [3];
	logic signed [42:0] res [3];
	logic [2:0] sat;
	logic [2:0][31:0] clip;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qm[i] = (dv_s[DIV_STEPS][i].ovf || dv_s[DIV_STEPS][i].q > 42'(QCAP))
				? QCAP : dv_s[DIV_STEPS][i].q[40:0];
			qs[i] = cr_s[DIV_STEPS].neg[i] ? -$signed({2'b00, qm[i]})
				: $signed({2'b00, qm[i]});
			res[i] = 43'($signed(cr_s[DIV_STEPS].x[i])) - qs[i];
			if (res[i] > 43'sd2147483647) begin
				clip[i] = 32'h7fff_ffff;
				sat[i] = 1'b1;
			end else if (res[i] < -43'sd2147483648) begin
				clip[i] = 32'h8000_0000;
				sat[i] = 1'b1;
			end else begin
				clip[i] = res[i][31:0];
				sat[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cr_s[DIV_STEPS].par) begin
				out_item <= '{out_x: '0, out_y: '0, out_z: '0, parallel: 1'b1,
					saturated: 1'b0};
			end else begin
				out_item <= '{out_x: clip[0], out_y: clip[1], out_z: clip[2],
					parallel: 1'b0, saturated: |sat};
			end
		end
	end

endmodule
`default_nettype wire

@@ sim/oblique_plane_projection_tb.sv @@
// Self-checking testbench for the oblique plane projector against a predictor.
`timescale 1ns / 1ps
module oblique_plane_projection_tb;
	import oproj_pkg::*;

	localparam logic OP_VECTOR = 1'b0;
	localparam logic OP_POINT = 1'b1;
	localparam int DRAIN_CYCLES = 60;
	localparam int STALL_LIMIT = 5000;
	localparam int NUM_PHASES = 11;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	logic signed [31:0] plane_normal [3];
	logic signed [31:0] proj_dir [3];
	logic signed [63:0] plane_offset;
	logic [62:0] ortho_tol;

	in_item_t pending_items [$];
	out_item_t expected_points [$];
	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	bit took = 1'b0;

	oblique_plane_projection i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic out_item_t project_item(in_item_t it);
		logic signed [127:0] den, num, a, b, coord, qs, diff;
		logic [127:0] dmag, nmag, pmag, q;
		logic signed [31:0] xin [3];
		logic signed [31:0] res [3];
		logic sat;
		out_item_t r;
		xin[0] = it.in_x;
		xin[1] = it.in_y;
		xin[2] = it.in_z;
		den = 0;
		num = 0;
		sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a = plane_normal[i];
			b = proj_dir[i];
			coord = xin[i];
			den = den + a * b;
			num = num + a * coord;
		end
		r = '0;
		dmag = den < 0 ? -den : den;
		if (dmag <= {65'd0, ortho_tol}) begin
			r.parallel = 1'b1;
			return r;
		end
		if (it.opcode == OP_POINT) begin
			a = plane_offset;
			num = num - a;
		end
		nmag = num < 0 ? -num : num;
		for (int i = 0; i < 3; i++) begin
			b = proj_dir[i];
			pmag = b < 0 ? -b : b;
			q = nmag * pmag / dmag;
			if (q > {87'd0, QCAP})
				q = {87'd0, QCAP};
			qs = q;
			if ((num < 0) ^ (b < 0) ^ (den < 0))
				qs = -qs;
			coord = xin[i];
			diff = coord - qs;
			if (diff > 128'sd2147483647) begin
				res[i] = 32'sh7fffffff;
				sat = 1'b1;
			end else if (diff < -128'sd2147483648) begin
				res[i] = 32'sh80000000;
				sat = 1'b1;
			end else begin
				res[i] = diff[31:0];
			end
		end
		r.out_x = res[0];
		r.out_y = res[1];
		r.out_z = res[2];
		r.saturated = sat;
		return r;
	endfunction

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_stall <= 1'b0;
		end else begin
			out_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
			if (!in_valid || took) begin
				if (pending_items.size() > 0 && !($urandom_range(99) < idle_pct)) begin
					in_item <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		bit moved;
		took = arst_n && in_valid && !in_stall;
		moved = took || (cfg_valid && cfg_ready);
		if (took)
			expected_points.push_back(project_item(in_item));
		if (arst_n && out_valid && !out_stall) begin
			moved = 1'b1;
			if (expected_points.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transaction %h", $time, out_item);
			end else begin
				want = expected_points.pop_front();
				if (out_item.out_x !== want.out_x || out_item.out_y !== want.out_y
					|| out_item.out_z !== want.out_z || out_item.parallel !== want.parallel
					|| out_item.saturated !== want.saturated) begin
					mismatches++;
					$display("%0t: mismatch expected x=%h y=%h z=%h par=%b sat=%b",
						$time, want.out_x, want.out_y, want.out_z, want.parallel, want.saturated);
					$display("%0t:          actual   x=%h y=%h z=%h par=%b sat=%b",
						$time, out_item.out_x, out_item.out_y, out_item.out_z,
						out_item.parallel, out_item.saturated);
				end
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[oblique_plane_projection] ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [3:0] idx, logic [63:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_NORMAL_X: plane_normal[0] = data[31:0];
			REG_NORMAL_Y: plane_normal[1] = data[31:0];
			REG_NORMAL_Z: plane_normal[2] = data[31:0];
			REG_DIR_X: proj_dir[0] = data[31:0];
			REG_DIR_Y: proj_dir[1] = data[31:0];
			REG_DIR_Z: proj_dir[2] = data[31:0];
			REG_PLANE_OFFSET: plane_offset = data;
			REG_ORTHO_TOL: ortho_tol = data[62:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2, 3: return $urandom;
			default: return 32'($signed($urandom_range(2097152))) - 32'sd1048576;
		endcase
	endfunction

	task automatic set_vectors(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
		logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		write_reg(REG_NORMAL_X, {32'd0, nx});
		write_reg(REG_NORMAL_Y, {32'd0, ny});
		write_reg(REG_NORMAL_Z, {32'd0, nz});
		write_reg(REG_DIR_X, {32'd0, px});
		write_reg(REG_DIR_Y, {32'd0, py});
		write_reg(REG_DIR_Z, {32'd0, pz});
	endtask

	task automatic queue_item(logic op, logic [31:0] x, logic [31:0] y, logic [31:0] z);
		in_item_t it;
		it.opcode = op;
		it.in_x = x;
		it.in_y = y;
		it.in_z = z;
		pending_items.push_back(it);
	endtask

	task automatic wait_idle();
		while (pending_items.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		plane_normal = '{32'sd0, 32'sd0, 32'sd65536};
		proj_dir = '{32'sd0, 32'sd0, 32'sd65536};
		plane_offset = '0;
		ortho_tol = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 54; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 54; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			case (ph)
				0: begin
					queue_item(OP_VECTOR, 0, 0, 0);
					queue_item(OP_POINT, 0, 0, 0);
					foreach (plane_normal[k]) begin
						queue_item(OP_VECTOR, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
						queue_item(OP_POINT, 32'h80000000, 32'h7fffffff, 32'h80000000);
					end
					queue_item(OP_POINT, 32'hffffffff, 32'h00010000, 32'hfffe0000);
					queue_item(OP_VECTOR, 32'h12345678, 32'hedcba987, 32'h00000001);
				end
				1: begin
					set_vectors(32'h00010000, 32'h00008000, 32'hffff0000,
						32'h00004000, 32'hfffe0000, 32'h00030000);
					write_reg(REG_PLANE_OFFSET, 64'h0000_0003_8000_0000);
					write_reg(REG_ORTHO_TOL, 64'h0000_0000_0000_1000);
					write_reg(4'd9, {32'd0, $urandom});
				end
				2: begin
					set_vectors(32'h7fffffff, 32'h80000000, 32'h7fffffff,
						32'h80000000, 32'h80000000, 32'h7fffffff);
					write_reg(REG_PLANE_OFFSET, 64'h8000_0000_0000_0000);
					write_reg(REG_ORTHO_TOL, 64'd0);
				end
				3: begin
					write_reg(REG_PLANE_OFFSET, 64'h7fff_ffff_ffff_ffff);
					write_reg(REG_ORTHO_TOL, 64'hffff_ffff_ffff_ffff);
					write_reg(4'd15, 64'hffff_ffff_ffff_ffff);
				end
				4: begin
					set_vectors(32'h00010000, 0, 0, 0, 32'h00010000, 0);
					write_reg(REG_ORTHO_TOL, 64'd0);
				end
				5: begin
					set_vectors(32'h00000001, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
					write_reg(REG_PLANE_OFFSET, 64'hffff_ffff_ffff_ffff);
				end
				default: begin
					set_vectors(rand_coord(), rand_coord(), rand_coord(),
						rand_coord(), rand_coord(), rand_coord());
					write_reg(REG_PLANE_OFFSET, $urandom_range(1) ? {$urandom, $urandom}
						: 64'($signed($urandom_range(65535)) - 32'sd32768) << 24);
					write_reg(REG_ORTHO_TOL, $urandom_range(3) == 0 ? {$urandom, $urandom}
						: 64'($urandom_range(255)));
					write_reg(4'(8 + $urandom_range(7)), {$urandom, $urandom});
				end
			endcase
			for (int n = 0; n < (ph == 0 ? 20 : 113); n++)
				queue_item(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord());
			wait_idle();
		end

		if (mismatches == 0)
			$display("[oblique_plane_projection] OK");
		else
			$display("[oblique_plane_projection] ERROR");
		$finish;
	end

endmodule
